[sv/ksrc_pkg.sv]
// ----------------------------------------------------------------------------
// ksrc_pkg
// Shared types and constants for the k-mer shift and reverse complement block.
// ----------------------------------------------------------------------------
package ksrc_pkg;

  localparam int unsigned MaxBases = 32;
  localparam int unsigned BaseW    = 2;
  localparam int unsigned KmerW    = MaxBases * BaseW;
  localparam int unsigned LenW     = 6;
  localparam int unsigned LaneW    = 5;

  localparam logic [LenW-1:0] KLenReset = 6'd31;

  // operation codes carried in the kind field
  localparam logic [1:0] KindAppend  = 2'd0;
  localparam logic [1:0] KindPrepend = 2'd1;
  localparam logic [1:0] KindClear   = 2'd2;

  localparam logic [BaseW-1:0] BaseT = 2'd3;

  typedef logic [MaxBases-1:0][BaseW-1:0] lanes_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [BaseW-1:0] base;
  } in_req_t;

  typedef struct packed {
    logic [KmerW-1:0] kmer_value;
    logic [KmerW-1:0] reverse_complement;
  } out_res_t;

endpackage

[sv/kmer_shift_and_reverse_complement.sv]
// ----------------------------------------------------------------------------
// kmer_shift_and_reverse_complement
// Holds one 2-bit packed DNA k-mer and returns it with its reverse complement
// after every append, prepend or clear request.
// ----------------------------------------------------------------------------
// The shift, the length mask and the reverse complement are done between the
// k-mer register and the result register, so a new request is taken every
// cycle while in_stall_o is low. A two-entry output stage (result register
// plus skid register, which takes a result while the consumer stalls) keeps
// requests flowing, and in_stall_o rises only when both entries are full.
// k_len must be written through cfg_we_i/cfg_wdata_i only while the block is
// idle, which the block does not enforce; 0 acts as 1, values above 32 as 32.
// ----------------------------------------------------------------------------
module kmer_shift_and_reverse_complement
  import ksrc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_req_t         in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_res_t        out_res_o
);

  logic [LenW-1:0] k_len_q;
  logic [LenW-1:0] k_eff;
  lanes_t          kmer_q, kmer_d;
  lanes_t          len_mask;
  lanes_t          cur;
  lanes_t          rc;
  out_res_t        res_d;
  out_res_t        out_q, skid_q;
  logic            out_valid_q, skid_valid_q;
  logic            in_acc, out_free;

  assign in_acc   = in_valid_i & ~skid_valid_q;
  assign out_free = ~out_valid_q | ~out_stall_i;

  // effective length, clamped to 1..MaxBases
  always_comb begin
    if (k_len_q == '0) begin
      k_eff = 6'd1;
    end else if (k_len_q > LenW'(MaxBases)) begin
      k_eff = LenW'(MaxBases);
    end else begin
      k_eff = k_len_q;
    end
  end

  always_comb begin
    logic [LenW-1:0] lane;
    logic [LenW-1:0] src;
    for (int i = 0; i < MaxBases; i++) begin
      lane        = LenW'(i);
      len_mask[i] = (lane < k_eff) ? BaseT : '0;
      cur[i]      = kmer_q[i] & len_mask[i];
    end
    for (int i = 0; i < MaxBases; i++) begin
      lane = LenW'(i);
      unique case (in_req_i.kind)
        KindAppend: begin
          if (lane == k_eff - 6'd1) begin
            kmer_d[i] = in_req_i.base;
          end else if (i < MaxBases - 1) begin
            kmer_d[i] = cur[(i + 1) % MaxBases] & len_mask[i];
          end else begin
            kmer_d[i] = '0;
          end
        end
        KindPrepend: begin
          if (i == 0) begin
            kmer_d[i] = in_req_i.base;
          end else begin
            kmer_d[i] = cur[(i + MaxBases - 1) % MaxBases] & len_mask[i];
          end
        end
        KindClear: kmer_d[i] = '0;
        default:   kmer_d[i] = cur[i];
      endcase
    end
    // base i of the result is the complement of base k-1-i
    for (int i = 0; i < MaxBases; i++) begin
      lane  = LenW'(i);
      src   = k_eff - 6'd1 - lane;
      rc[i] = (lane < k_eff) ? ~kmer_d[src[LaneW-1:0]] : '0;
    end
    res_d.kmer_value         = kmer_d;
    res_d.reverse_complement = rc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_len_q <= KLenReset;
    end else if (cfg_we_i) begin
      k_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_q <= '0;
    end else if (in_acc) begin
      kmer_q <= kmer_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res_d;
      end
    end else if (in_acc) begin
      skid_q <= res_d;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while result register empty");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted request produced no result");

  a_kmer_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ((kmer_q & ~$past(len_mask)) == '0))
    else $error("k-mer bits above the length not cleared");

endmodule
